[src/sort_and_merge_two_lists_macros.svh]
// Assertion macros used by the checker file of the two-list sort and merge block.
// No dependencies.
`ifndef SORT_AND_MERGE_TWO_LISTS_MACROS_SVH
`define SORT_AND_MERGE_TWO_LISTS_MACROS_SVH

// same-cycle implication
`define SMTL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smtl assertion failed");

// next-cycle implication
`define SMTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smtl assertion failed");

`endif

[src/smtl_pkg.sv]
// Package for the two-list sort and merge block: item types and kind codes.
// No dependencies.
`default_nettype none

package smtl_pkg;

    localparam int VALUE_W = 32;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_GO     = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      last;
        logic                      overflow;
    } t_out_item;

endpackage

`default_nettype wire

[src/smtl_ifs.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on smtl_pkg.
`default_nettype none

interface smtl_in_if;
    logic                valid;
    logic                ready;
    smtl_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface smtl_out_if;
    logic                valid;
    logic                ready;
    smtl_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/sort_and_merge_two_lists.sv]
// Two-list sort and merge. Load items give no result.
// A go item sorts list one, then list two, in place by insertion sort through one
// read and one write port per list RAM. The merge then reads both lists and gives
// one result per pick, held while the sink stalls. Reset clears counts, overflow
// flag and control; list RAMs are not cleared.
`default_nettype none

module sort_and_merge_two_lists #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    smtl_in_if.sink     i_in,
    smtl_out_if.source  o_out
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int VW = smtl_pkg::VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SORT_INIT, S_RDK, S_LDK, S_CMP, S_PUT, S_MRD, S_MCMP, S_MOUT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_cnt_a, r_cnt_b, r_k, r_slot, r_i, r_j;
    logic                r_drop, r_sel;
    logic signed [VW-1:0] r_held;
    smtl_pkg::t_out_item r_out;

    logic                in_acc, room_a, room_b, ld_a, ld_b, merging;
    logic [CW-1:0]       n_cur, s_waddr, s_raddr, i_nx, j_nx;
    logic                s_we, less, has_a, has_b, take_a, take_b, last_nx;
    logic signed [VW-1:0] s_wdata, cur_rdata, rd_a, rd_b, pick;
    logic                we_a, we_b;
    logic [AW-1:0]       waddr_a, waddr_b, raddr_a, raddr_b;
    logic [VW-1:0]       wdata_a, wdata_b;

    assign in_acc    = i_in.valid && i_in.ready;
    assign room_a    = r_cnt_a < CW'(LIST_DEPTH);
    assign room_b    = r_cnt_b < CW'(LIST_DEPTH);
    assign ld_a      = in_acc && (i_in.payload.kind == smtl_pkg::KIND_FIRST) && room_a;
    assign ld_b      = in_acc && (i_in.payload.kind == smtl_pkg::KIND_SECOND) && room_b;
    assign n_cur     = r_sel ? r_cnt_b : r_cnt_a;
    assign cur_rdata = r_sel ? rd_b : rd_a;
    assign less      = r_held < cur_rdata;
    assign merging   = r_state inside {S_MRD, S_MCMP, S_MOUT};

    // sort-side RAM access
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_slot;
        s_wdata = r_held;
        s_raddr = r_k;
        case (r_state)
            S_LDK: begin
                s_raddr = r_k - 1'b1;
            end
            S_CMP: begin
                s_we    = 1'b1;
                s_wdata = less ? cur_rdata : r_held;
                s_raddr = r_slot - CW'(2);
            end
            S_PUT: begin
                s_we    = 1'b1;
                s_waddr = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        we_a    = ld_a || (s_we && !r_sel);
        we_b    = ld_b || (s_we && r_sel);
        waddr_a = ld_a ? r_cnt_a[AW-1:0] : s_waddr[AW-1:0];
        waddr_b = ld_b ? r_cnt_b[AW-1:0] : s_waddr[AW-1:0];
        wdata_a = ld_a ? i_in.payload.value : s_wdata;
        wdata_b = ld_b ? i_in.payload.value : s_wdata;
        raddr_a = merging ? r_i[AW-1:0] : s_raddr[AW-1:0];
        raddr_b = merging ? r_j[AW-1:0] : s_raddr[AW-1:0];
    end

    // merge pick
    always_comb begin
        has_a  = r_i < r_cnt_a;
        has_b  = r_j < r_cnt_b;
        take_a = 1'b0;
        take_b = 1'b0;
        pick   = rd_a;
        if (has_a && has_b) begin
            if (rd_a < rd_b) begin
                take_a = 1'b1;
            end else if (rd_b < rd_a) begin
                take_b = 1'b1;
                pick   = rd_b;
            end else begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
        end else if (has_a) begin
            take_a = 1'b1;
        end else begin
            take_b = 1'b1;
            pick   = rd_b;
        end
        i_nx    = r_i + CW'(take_a);
        j_nx    = r_j + CW'(take_b);
        last_nx = !(i_nx < r_cnt_a) && !(j_nx < r_cnt_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.payload.kind)
                            smtl_pkg::KIND_FIRST: begin
                                if (room_a) r_cnt_a <= r_cnt_a + 1'b1;
                                else        r_drop  <= 1'b1;
                            end
                            smtl_pkg::KIND_SECOND: begin
                                if (room_b) r_cnt_b <= r_cnt_b + 1'b1;
                                else        r_drop  <= 1'b1;
                            end
                            smtl_pkg::KIND_GO: begin
                                r_sel   <= 1'b0;
                                r_k     <= CW'(1);
                                r_state <= S_SORT_INIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SORT_INIT: begin
                    if (r_k < n_cur) begin
                        r_state <= S_RDK;
                    end else if (!r_sel) begin
                        r_sel <= 1'b1;
                        r_k   <= CW'(1);
                    end else if (r_cnt_a == '0 && r_cnt_b == '0) begin
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_MRD;
                    end
                end
                S_RDK: begin
                    r_state <= S_LDK;
                end
                S_LDK: begin
                    r_held  <= cur_rdata;
                    r_slot  <= r_k;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (less) begin
                        r_slot <= r_slot - 1'b1;
                        if (r_slot == CW'(1)) r_state <= S_PUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SORT_INIT;
                    end
                end
                S_PUT: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_SORT_INIT;
                end
                S_MRD: begin
                    r_state <= S_MCMP;
                end
                S_MCMP: begin
                    r_out.merged_value <= pick;
                    r_out.last         <= last_nx;
                    r_out.overflow     <= r_drop;
                    r_i                <= i_nx;
                    r_j                <= j_nx;
                    r_state            <= S_MOUT;
                end
                S_MOUT: begin
                    if (o_out.ready) begin
                        if (r_out.last) begin
                            r_cnt_a <= '0;
                            r_cnt_b <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MCMP;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = (r_state == S_MOUT);
    assign o_out.payload = r_out;

    smtl_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    smtl_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

endmodule

`default_nettype wire

[src/smtl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/smtl_checker.sv]
// Port-level checker for the two-list sort and merge block, bound to the top level.
// Depends on smtl_pkg, the top level and sort_and_merge_two_lists_macros.svh.
`default_nettype none
`include "sort_and_merge_two_lists_macros.svh"

module smtl_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic [1:0]          i_in_kind,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire smtl_pkg::t_out_item i_out_payload
);

    logic in_acc, out_wait, go_acc, load_acc;

    assign in_acc   = i_in_valid && i_in_ready;
    assign out_wait = i_out_valid && !i_out_ready;
    assign go_acc   = in_acc && (i_in_kind == smtl_pkg::KIND_GO);
    assign load_acc = in_acc && (i_in_kind inside {smtl_pkg::KIND_FIRST, smtl_pkg::KIND_SECOND});

    `SMTL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid && $stable(i_out_payload))
    `SMTL_ASSERT_IMP(a_no_accept_while_out, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `SMTL_ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, go_acc, !i_in_ready)
    `SMTL_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n, load_acc, i_in_ready)

endmodule

bind sort_and_merge_two_lists smtl_checker u_smtl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_kind     (i_in.payload.kind),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for sort_and_merge_two_lists: loads two lists, fires go items and
// compares every merged item against a local list tracker, under random flow control.
// Depends on smtl_pkg, smtl_ifs and sort_and_merge_two_lists.
module tb;

    localparam int          VW           = smtl_pkg::VALUE_W;
    localparam int          LIST_DEPTH   = 32;
    localparam int          ITEM_TARGET  = 430;
    localparam int          TAIL_CYCLES  = 3000;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          PRINT_LIMIT  = 20;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;

    typedef logic signed [VW-1:0] t_value_q[$];
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                tx_valid = 1'b0;
    smtl_pkg::t_in_item  tx_item  = '0;
    logic                rx_ready = 1'b0;
    logic                hold_on  = 1'b0;
    t_rx_mode            rx_mode  = RX_OPEN;
    int                  mode_left = 0;

    int unsigned cycle_count = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          batches = 0;
    int          overflow_batches = 0;
    int          results_checked = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    t_value_q            first_vals;
    t_value_q            second_vals;
    bit                  batch_dropped = 1'b0;
    smtl_pkg::t_out_item pending_merged[$];

    smtl_in_if  in_ch();
    smtl_out_if out_ch();

    assign in_ch.valid   = tx_valid;
    assign in_ch.payload = tx_item;
    assign out_ch.ready  = rx_ready;

    sort_and_merge_two_lists #(.LIST_DEPTH(LIST_DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial forever #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d merged items outstanding",
                 cycle_count, pending_merged.size());
        $display("FAIL");
        $finish;
    end

    // receiver flow control: pattern switches at random among open, coin-toss, sparse and periodic modes
    always @(posedge i_clk) begin : rx_pattern
        bit open;
        case (rx_mode)
            RX_OPEN:     open = 1'b1;
            RX_COIN:     open = $urandom_range(0, 1);
            RX_SPARSE:   open = ($urandom_range(0, 3) == 0);
            default:     open = (cycle_count % 3) != 0;
        endcase
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(8, 64);
        end else begin
            mode_left <= mode_left - 1;
        end
        rx_ready <= open && !hold_on;
    end

    task automatic hold_receiver(input int cycles);
        fork
            begin
                hold_on <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
    endtask

    task automatic report_mismatch(input string what);
        if (errors < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    function automatic t_value_q sort_ascending(t_value_q src);
        t_value_q dst;
        int pos;
        foreach (src[k]) begin
            pos = dst.size();
            while (pos > 0 && src[k] < dst[pos-1])
                pos--;
            dst.insert(pos, src[k]);
        end
        return dst;
    endfunction

    task automatic merge_lists();
        t_value_q            a;
        t_value_q            b;
        int                  ia;
        int                  ib;
        smtl_pkg::t_out_item r;
        a  = sort_ascending(first_vals);
        b  = sort_ascending(second_vals);
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size()) begin
            if (ia < a.size() && ib < b.size()) begin
                if (a[ia] < b[ib]) begin
                    r.merged_value = a[ia];
                    ia++;
                end else if (b[ib] < a[ia]) begin
                    r.merged_value = b[ib];
                    ib++;
                end else begin
                    r.merged_value = a[ia];
                    ia++;
                    ib++;
                end
            end else if (ia < a.size()) begin
                r.merged_value = a[ia];
                ia++;
            end else begin
                r.merged_value = b[ib];
                ib++;
            end
            r.last     = 1'b0;
            r.overflow = batch_dropped;
            pending_merged.insert(pending_merged.size(), r);
        end
        if (a.size() + b.size() > 0)
            pending_merged[pending_merged.size()-1].last = 1'b1;
        if (batch_dropped)
            overflow_batches++;
        first_vals.delete();
        second_vals.delete();
        batch_dropped = 1'b0;
    endtask

    task automatic track_item(input logic [1:0] kind, input logic signed [VW-1:0] value);
        if (kind != KIND_UNUSED)
            items_sent++;
        case (kind)
            smtl_pkg::KIND_FIRST: begin
                if (first_vals.size() < LIST_DEPTH)
                    first_vals.insert(first_vals.size(), value);
                else batch_dropped = 1'b1;
            end
            smtl_pkg::KIND_SECOND: begin
                if (second_vals.size() < LIST_DEPTH)
                    second_vals.insert(second_vals.size(), value);
                else batch_dropped = 1'b1;
            end
            smtl_pkg::KIND_GO: begin
                batches++;
                merge_lists();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : check_results
        smtl_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_merged.size() == 0) begin
                report_mismatch($sformatf("unexpected item value %0d",
                                          out_ch.payload.merged_value));
            end else begin
                want = pending_merged.pop_front();
                results_checked++;
                if (out_ch.payload.merged_value !== want.merged_value)
                    report_mismatch($sformatf("merged_value got %0d want %0d",
                                              out_ch.payload.merged_value, want.merged_value));
                if (out_ch.payload.last !== want.last)
                    report_mismatch($sformatf("last got %b want %b",
                                              out_ch.payload.last, want.last));
                if (out_ch.payload.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b",
                                              out_ch.payload.overflow, want.overflow));
            end
        end
    end

    // bursts of random length separated by random gaps
    task automatic send_item(input logic [1:0] kind, input logic signed [VW-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                if (tx_valid) tx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        tx_valid <= 1'b1;
        tx_item  <= {kind, value};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_item(kind, value);
        burst_left--;
    endtask

    task automatic stop_sending();
        if (tx_valid) tx_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [VW-1:0] batch_value(input int style,
            input logic signed [VW-1:0] base, input int idx);
        case (style)
            0: return $urandom;
            1: return $signed(VW'($urandom_range(0, 8))) - 4;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            3: return base - idx * 5;
            default: return base + idx * 5;
        endcase
    endfunction

    task automatic test_extremes();
        send_item(smtl_pkg::KIND_FIRST,  32'sh7fffffff);
        send_item(smtl_pkg::KIND_FIRST,  32'sh80000000);
        send_item(smtl_pkg::KIND_SECOND, 32'sh80000000);
        send_item(smtl_pkg::KIND_FIRST,  0);
        send_item(smtl_pkg::KIND_SECOND, 1);
        send_item(smtl_pkg::KIND_FIRST,  -1);
        send_item(smtl_pkg::KIND_SECOND, 32'sh7fffffff);
        send_item(smtl_pkg::KIND_SECOND, -1);
        send_item(smtl_pkg::KIND_SECOND, -1);
        send_item(smtl_pkg::KIND_GO,     32'sh7fffffff);
    endtask

    task automatic test_empty_and_unused();
        send_item(smtl_pkg::KIND_GO, 0);
        send_item(KIND_UNUSED, 32'sh5a5a5a5a);
        send_item(smtl_pkg::KIND_FIRST, 7);
        send_item(smtl_pkg::KIND_FIRST, 7);
        send_item(KIND_UNUSED, -3);
        send_item(smtl_pkg::KIND_FIRST, 7);
        send_item(smtl_pkg::KIND_GO, -1);
        send_item(smtl_pkg::KIND_SECOND, 5);
        send_item(smtl_pkg::KIND_SECOND, -5);
        send_item(smtl_pkg::KIND_GO, 32'sh80000000);
        send_item(KIND_UNUSED, 0);
        send_item(smtl_pkg::KIND_GO, 0);
    endtask

    // both lists past full, first list in reverse order for the longest sort
    task automatic test_full_list();
        logic signed [VW-1:0] base;
        base = $urandom;
        for (int k = 0; k < LIST_DEPTH + 2; k++)
            send_item(smtl_pkg::KIND_FIRST, base - k * 3);
        for (int k = 0; k < LIST_DEPTH + 1; k++)
            send_item(smtl_pkg::KIND_SECOND, $urandom);
        send_item(smtl_pkg::KIND_GO, 0);
        send_item(smtl_pkg::KIND_SECOND, 42);
        send_item(smtl_pkg::KIND_GO, 0);
    endtask

    // receiver blocked while a batch of 24 items per list and the next loads are offered
    task automatic test_backpressure();
        hold_receiver(900);
        gaps_on = 1'b0;
        for (int k = 0; k < 24; k++)
            send_item(smtl_pkg::KIND_FIRST, $urandom);
        for (int k = 0; k < 24; k++)
            send_item(smtl_pkg::KIND_SECOND, $signed(VW'($urandom_range(0, 31))) - 16);
        send_item(smtl_pkg::KIND_GO, 0);
        for (int k = 0; k < 6; k++)
            send_item(smtl_pkg::KIND_FIRST, $urandom);
        send_item(smtl_pkg::KIND_GO, 0);
        gaps_on = 1'b1;
    endtask

    task automatic send_random_batch();
        int n_first;
        int n_second;
        int style;
        int r;
        logic signed [VW-1:0] base;
        r = $urandom_range(0, 24);
        if (r == 0) begin
            n_first  = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
            n_second = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
        end else if (r < 3) begin
            n_first  = 0;
            n_second = $urandom_range(1, 8);
        end else if (r < 5) begin
            n_first  = $urandom_range(1, 8);
            n_second = 0;
        end else begin
            n_first  = $urandom_range(0, 8);
            n_second = $urandom_range(0, 8);
        end
        style   = $urandom_range(0, 4);
        base    = $urandom;
        gaps_on = ($urandom_range(0, 4) != 0);
        while (n_first + n_second > 0) begin
            if ($urandom_range(0, 15) == 0)
                send_item(KIND_UNUSED, $urandom);
            if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1))) begin
                send_item(smtl_pkg::KIND_FIRST, batch_value(style, base, n_first));
                n_first--;
            end else begin
                send_item(smtl_pkg::KIND_SECOND, batch_value(style, base, n_second));
                n_second--;
            end
        end
        send_item(smtl_pkg::KIND_GO, $urandom);
        if ($urandom_range(0, 9) == 0)
            send_item(smtl_pkg::KIND_GO, $urandom);
    endtask

    task automatic test_random_batches();
        while (items_sent < ITEM_TARGET)
            send_random_batch();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_empty_and_unused();
        test_full_list();
        test_backpressure();
        test_random_batches();
        stop_sending();
        while (pending_merged.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d items in %0d go batches (%0d with overflow)",
                 items_sent, batches, overflow_batches);
        $display("checked %0d merged items, %0d mismatches, %0d cycles",
                 results_checked, errors, cycle_count);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/smtl_pkg.sv
src/smtl_ifs.sv
src/smtl_ram.sv
src/sort_and_merge_two_lists.sv
src/smtl_checker.sv
tb/tb.sv
